// ===== design/ofdt_pkg.sv =====
// Shared constants, codes, command/status structs and index helpers for the descriptor table.
`default_nettype none
package ofdt_pkg;

	localparam int ENTRIES     = 16;
	localparam int INODE_BITS  = 10;
	localparam int OFFSET_BITS = 24;
	localparam int SLOT_BITS   = 4;
	localparam int CMD_BITS    = 2;
	localparam int STAT_BITS   = 2;
	localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DATA_BITS   = INODE_BITS + OFFSET_BITS;

	localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd3;

	localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL = 2'd2;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

	// Controller to datapath
	typedef struct packed {
		logic                 capture;   // latch the input beat
		logic                 rd_en;     // read the slot store
		logic                 wr_en;     // write the slot store
		logic                 set_act;   // mark slot active
		logic                 clr_act;   // mark slot inactive
		logic                 use_slot;  // access at the requested slot, not the scan index
		logic [IDX_BITS-1:0]  idx;       // scan index
		logic                 load;      // load the result register
		logic [STAT_BITS-1:0] status;
		logic                 slot_en;   // result carries a slot number
		logic [IDX_BITS-1:0]  out_slot;
		logic                 data_en;   // result carries the stored inode and offset
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic act_idx;   // active flag at the scan index
		logic slot_ok;   // requested slot is in range and active
		logic hit_s1;    // last read entry was active and its inode matched
	} dp_stat_t;

	function automatic logic [SLOT_BITS-1:0] idx_to_slot(input logic [IDX_BITS-1:0] i);
		logic [SLOT_BITS+IDX_BITS-1:0] w;
		w = {{SLOT_BITS{1'b0}}, i};
		return w[SLOT_BITS-1:0];
	endfunction

	function automatic logic [IDX_BITS-1:0] slot_to_idx(input logic [SLOT_BITS-1:0] s);
		logic [SLOT_BITS+IDX_BITS-1:0] w;
		w = {{IDX_BITS{1'b0}}, s};
		return w[IDX_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/ofdt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ofdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/ofdt_ctrl.sv =====
// Command sequencer: scans slots for add and find, checks and finishes get and remove.
`default_nettype none
module ofdt_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ofdt_pkg::CMD_BITS-1:0] in_cmd,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	input  wire ofdt_pkg::dp_stat_t           stat,
	output ofdt_pkg::ctrl_cmd_t               cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_FIND = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_GET  = 3'd4;

	logic [2:0]                      state_q, state_d;
	logic [ofdt_pkg::CMD_BITS-1:0]   cmd_q, cmd_d;
	logic [ofdt_pkg::IDX_BITS-1:0]   cnt_q, cnt_d;
	logic                            more_q, more_d;
	logic                            vld_s1, vld_d;
	logic [ofdt_pkg::IDX_BITS-1:0]   idx_s1, idx_d;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            emit_hit, emit_miss;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);
	assign emit_hit  = vld_s1 && stat.hit_s1;
	assign emit_miss = vld_s1 && !stat.hit_s1 && (idx_s1 == ofdt_pkg::LAST_IDX);

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		cnt_d   = cnt_q;
		more_d  = more_q;
		vld_d   = vld_s1;
		idx_d   = idx_s1;
		cmd     = '0;
		cmd.idx = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd_d       = in_cmd;
					cnt_d       = '0;
					more_d      = 1'b1;
					vld_d       = 1'b0;
					unique case (in_cmd)
						ofdt_pkg::CMD_ADD:  state_d = S_ADD;
						ofdt_pkg::CMD_FIND: state_d = S_FIND;
						default:            state_d = S_CHK;
					endcase
				end
			end
			S_ADD: begin
				if (!stat.act_idx) begin
					if (out_free) begin
						cmd.wr_en    = 1'b1;
						cmd.set_act  = 1'b1;
						cmd.load     = 1'b1;
						cmd.status   = ofdt_pkg::ST_OK;
						cmd.slot_en  = 1'b1;
						cmd.out_slot = cnt_q;
						state_d      = S_IDLE;
					end
				end else if (cnt_q == ofdt_pkg::LAST_IDX) begin
					if (out_free) begin
						cmd.load   = 1'b1;
						cmd.status = ofdt_pkg::ST_FULL;
						state_d    = S_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_FIND: begin
				if (emit_hit || emit_miss) begin
					if (out_free) begin
						cmd.load     = 1'b1;
						cmd.status   = emit_hit ? ofdt_pkg::ST_OK : ofdt_pkg::ST_MISS;
						cmd.slot_en  = emit_hit;
						cmd.out_slot = idx_s1;
						state_d      = S_IDLE;
					end
				end else if (more_q) begin
					cmd.rd_en = 1'b1;
					vld_d     = 1'b1;
					idx_d     = cnt_q;
					cnt_d     = cnt_q + 1'b1;
					more_d    = (cnt_q != ofdt_pkg::LAST_IDX);
				end else begin
					vld_d = 1'b0;
				end
			end
			S_CHK: begin
				cmd.use_slot = 1'b1;
				if (!stat.slot_ok) begin
					if (out_free) begin
						cmd.load   = 1'b1;
						cmd.status = ofdt_pkg::ST_MISS;
						state_d    = S_IDLE;
					end
				end else if (cmd_q == ofdt_pkg::CMD_GET) begin
					cmd.rd_en = 1'b1;
					state_d   = S_GET;
				end else if (out_free) begin
					cmd.clr_act = 1'b1;
					cmd.load    = 1'b1;
					cmd.status  = ofdt_pkg::ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_GET: begin
				if (out_free) begin
					cmd.load    = 1'b1;
					cmd.status  = ofdt_pkg::ST_OK;
					cmd.data_en = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			vld_s1      <= vld_d;
			out_valid_q <= cmd.load ? 1'b1 : (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		cnt_q  <= cnt_d;
		more_q <= more_d;
		idx_s1 <= idx_d;
	end

endmodule
`default_nettype wire

// ===== design/ofdt_dp.sv =====
// Datapath: active flags, slot store, inode compare and the result register.
`default_nettype none
module ofdt_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ofdt_pkg::ctrl_cmd_t              cmd,
	output ofdt_pkg::dp_stat_t                    stat,
	input  wire logic [ofdt_pkg::SLOT_BITS-1:0]   slot,
	input  wire logic [ofdt_pkg::INODE_BITS-1:0]  inode,
	input  wire logic [ofdt_pkg::OFFSET_BITS-1:0] rw_offset,
	output logic      [ofdt_pkg::STAT_BITS-1:0]   status,
	output logic      [ofdt_pkg::SLOT_BITS-1:0]   slot_out,
	output logic      [ofdt_pkg::INODE_BITS-1:0]  inode_out,
	output logic      [ofdt_pkg::OFFSET_BITS-1:0] rw_offset_out
);

	logic                             active_q [ofdt_pkg::ENTRIES];
	logic [ofdt_pkg::SLOT_BITS-1:0]   slot_q;
	logic [ofdt_pkg::INODE_BITS-1:0]  inode_q;
	logic [ofdt_pkg::OFFSET_BITS-1:0] off_q;
	logic                             act_s1;
	logic [ofdt_pkg::IDX_BITS-1:0]    slot_idx;
	logic [ofdt_pkg::IDX_BITS-1:0]    acc_idx;
	logic [ofdt_pkg::DATA_BITS-1:0]   rdata;
	logic [ofdt_pkg::INODE_BITS-1:0]  rd_inode;
	logic [ofdt_pkg::OFFSET_BITS-1:0] rd_off;

	assign slot_idx = ofdt_pkg::slot_to_idx(slot_q);
	assign acc_idx  = cmd.use_slot ? slot_idx : cmd.idx;
	assign rd_inode = rdata[ofdt_pkg::DATA_BITS-1:ofdt_pkg::OFFSET_BITS];
	assign rd_off   = rdata[ofdt_pkg::OFFSET_BITS-1:0];

	assign stat.act_idx = active_q[cmd.idx];
	assign stat.slot_ok = (int'(slot_q) < ofdt_pkg::ENTRIES) && active_q[slot_idx];
	assign stat.hit_s1  = act_s1 && (rd_inode == inode_q);

	ofdt_ram #(
		.WIDTH(ofdt_pkg::DATA_BITS),
		.DEPTH(ofdt_pkg::ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(acc_idx),
		.wdata({inode_q, off_q}),
		.re   (cmd.rd_en),
		.raddr(acc_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ofdt_pkg::ENTRIES; i++) begin
				active_q[i] <= 1'b0;
			end
		end else if (cmd.set_act || cmd.clr_act) begin
			active_q[acc_idx] <= cmd.set_act;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q  <= slot;
			inode_q <= inode;
			off_q   <= rw_offset;
		end
		if (cmd.rd_en) begin
			act_s1 <= active_q[acc_idx];
		end
		if (cmd.load) begin
			status        <= cmd.status;
			slot_out      <= cmd.slot_en ? ofdt_pkg::idx_to_slot(cmd.out_slot) : '0;
			inode_out     <= cmd.data_en ? rd_inode : '0;
			rw_offset_out <= cmd.data_en ? rd_off : '0;
		end
	end

endmodule
`default_nettype wire

// ===== design/open_file_descriptor_table.sv =====
// Top level of the open-file descriptor table: sequencer plus datapath.
//
//  channel | direction | handshake               | beat contents
//  --------+-----------+-------------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall     | cmd, slot, inode, rw_offset
//  out     | source    | out_valid / out_stall   | status, slot_out, inode_out,
//          |           |                         | rw_offset_out
//
// One command at a time. Get and remove check the requested slot and finish from it;
// add scans the active flags for a free slot and find scans the slot store, visiting
// up to ENTRIES slots (sixteen here). The scan counter steps once a cycle through the
// active flags, and for find through the slot store's single read port.
// Reset clears the active flags, the sequencer state and the output valid; the slot
// store itself is not cleared; a slot's data is used only after add has written it.
// A finished result sits in the output register; the next command is accepted while it
// waits, and its final step holds until the output register is free.
`default_nettype none
module open_file_descriptor_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [ofdt_pkg::CMD_BITS-1:0]    cmd,
	input  wire logic [ofdt_pkg::SLOT_BITS-1:0]   slot,
	input  wire logic [ofdt_pkg::INODE_BITS-1:0]  inode,
	input  wire logic [ofdt_pkg::OFFSET_BITS-1:0] rw_offset,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [ofdt_pkg::STAT_BITS-1:0]   status,
	output logic      [ofdt_pkg::SLOT_BITS-1:0]   slot_out,
	output logic      [ofdt_pkg::INODE_BITS-1:0]  inode_out,
	output logic      [ofdt_pkg::OFFSET_BITS-1:0] rw_offset_out
);

	// Command and status between sequencer and datapath
	ofdt_pkg::ctrl_cmd_t ctl;
	ofdt_pkg::dp_stat_t  dps;

	// Sequencer: owns the handshakes, the scan counter and the find read pipeline
	ofdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_cmd   (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (dps),
		.cmd      (ctl)
	);

	// Datapath: hold the beat, the active flags, the slot store and the result register
	ofdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl),
		.stat         (dps),
		.slot         (slot),
		.inode        (inode),
		.rw_offset    (rw_offset),
		.status       (status),
		.slot_out     (slot_out),
		.inode_out    (inode_out),
		.rw_offset_out(rw_offset_out)
	);

endmodule
`default_nettype wire
